// ===== design/swd_write_transfer_serializer_defines.svh =====
// ----------------------------------------------------------------------------
// SWD write serializer assertion macros
// Shared property wrappers for the serializer checker.
// ----------------------------------------------------------------------------
`ifndef SWD_WRITE_TRANSFER_SERIALIZER_DEFINES_SVH
`define SWD_WRITE_TRANSFER_SERIALIZER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while in reset
`define SWDW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset
`define SWDW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/swdw_pkg.sv =====
// ----------------------------------------------------------------------------
// SWD write serializer package
// Frame phase codes, field widths, item codes and the result type.
// ----------------------------------------------------------------------------
package swdw_pkg;

  localparam int unsigned DATA_BITS = 32;
  localparam int unsigned REQ_BITS  = 4;
  localparam int unsigned ACK_BITS  = 3;
  localparam int unsigned TURN_W    = 3;
  localparam int unsigned PHASE_W   = 6;

  // Item codes
  typedef enum logic {
    ACT_START = 1'b0,
    ACT_TICK  = 1'b1
  } action_e;

  // Frame phases
  localparam logic [PHASE_W-1:0] PH_START      = 6'd0;
  localparam logic [PHASE_W-1:0] PH_REQ0       = 6'd1;
  localparam logic [PHASE_W-1:0] PH_REQ3       = 6'd4;
  localparam logic [PHASE_W-1:0] PH_PARITY_REQ = 6'd5;
  localparam logic [PHASE_W-1:0] PH_STOP       = 6'd6;
  localparam logic [PHASE_W-1:0] PH_PARK       = 6'd7;
  localparam logic [PHASE_W-1:0] PH_TA1        = 6'd8;
  localparam logic [PHASE_W-1:0] PH_ACK0       = 6'd9;
  localparam logic [PHASE_W-1:0] PH_ACK2       = 6'd11;
  localparam logic [PHASE_W-1:0] PH_TA2        = 6'd12;
  localparam logic [PHASE_W-1:0] PH_DATA0      = 6'd13;
  localparam logic [PHASE_W-1:0] PH_DATA_LAST  = 6'd44;
  localparam logic [PHASE_W-1:0] PH_DATA_PAR   = 6'd45;

  // One result item
  typedef struct packed {
    logic                line_out;
    logic                line_drive;
    logic [ACK_BITS-1:0] ack_code;
    logic                done_res;
  } swdw_res_t;

endpackage

// ===== design/swdw_engine.sv =====
// ----------------------------------------------------------------------------
// SWD write serializer frame engine
// Holds the transfer state and works out one serial clock per tick item.
// ----------------------------------------------------------------------------
module swdw_engine (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            item_en_i,
  input  logic                            action_i,
  input  logic [swdw_pkg::REQ_BITS-1:0]   request_i,
  input  logic [swdw_pkg::DATA_BITS-1:0]  write_word_i,
  input  logic                            line_in_i,
  input  logic [swdw_pkg::TURN_W-1:0]     turnaround_i,
  output swdw_pkg::swdw_res_t             res_o
);
  import swdw_pkg::*;

  logic                 busy_q, busy_d;
  logic [PHASE_W-1:0]   phase_q, phase_d, phase_eff;
  logic [TURN_W-1:0]    turn_q, turn_d, turn_eff, turn_inc;
  logic [REQ_BITS-1:0]  request_q, request_d;
  logic [DATA_BITS-1:0] word_q, word_d;
  logic                 parity_q, parity_d;
  logic [ACK_BITS-1:0]  ack_q, ack_d;
  logic [1:0]           req_idx, ack_idx;
  logic                 req_bit;
  swdw_res_t            res;

  assign req_idx  = 2'(phase_eff - PH_REQ0);
  assign ack_idx  = 2'(phase_eff - PH_ACK0);
  assign req_bit  = request_q[req_idx];
  assign turn_inc = turn_eff + 3'd1;

  // Work out the next state and the line for this tick
  always_comb begin
    busy_d    = busy_q;
    request_d = request_q;
    word_d    = word_q;
    parity_d  = parity_q;
    ack_d     = ack_q;
    phase_eff = phase_q;
    turn_eff  = turn_q;
    res       = '{line_out: 1'b1, line_drive: 1'b1, ack_code: '0, done_res: 1'b0};

    // End a turnaround that has already run its count
    if (busy_q && (phase_q == PH_TA1 || phase_q == PH_TA2) && turn_q >= turnaround_i) begin
      phase_eff = phase_q + 6'd1;
      turn_eff  = '0;
    end
    phase_d = phase_eff;
    turn_d  = turn_eff;

    if (action_i == ACT_START) begin
      busy_d    = 1'b1;
      phase_d   = PH_START;
      turn_d    = '0;
      request_d = request_i;
      word_d    = write_word_i;
      parity_d  = 1'b0;
      ack_d     = '0;
    end else if (busy_q) begin
      case (phase_eff) inside
        PH_START: begin
          phase_d = phase_eff + 6'd1;
        end
        [PH_REQ0:PH_REQ3]: begin
          res.line_out = req_bit;
          parity_d     = parity_q ^ req_bit;
          phase_d      = phase_eff + 6'd1;
        end
        PH_PARITY_REQ: begin
          res.line_out = parity_q;
          parity_d     = 1'b0;
          phase_d      = phase_eff + 6'd1;
        end
        PH_STOP: begin
          res.line_out = 1'b0;
          phase_d      = phase_eff + 6'd1;
        end
        PH_PARK: begin
          phase_d = phase_eff + 6'd1;
        end
        PH_TA1, PH_TA2: begin
          res.line_out   = 1'b0;
          res.line_drive = 1'b0;
          if (turn_inc >= turnaround_i) begin
            phase_d = phase_eff + 6'd1;
            turn_d  = '0;
          end else begin
            turn_d = turn_inc;
          end
        end
        [PH_ACK0:PH_ACK2]: begin
          res.line_out   = 1'b0;
          res.line_drive = 1'b0;
          ack_d[ack_idx] = line_in_i;
          phase_d        = phase_eff + 6'd1;
        end
        [PH_DATA0:PH_DATA_LAST]: begin
          res.line_out = word_q[0];
          parity_d     = parity_q ^ word_q[0];
          word_d       = word_q >> 1;
          phase_d      = phase_eff + 6'd1;
        end
        default: begin
          // Data parity closes the transfer
          res.line_out = parity_q;
          res.ack_code = ack_q;
          res.done_res = 1'b1;
          busy_d       = 1'b0;
          phase_d      = PH_START;
          turn_d       = '0;
        end
      endcase
    end
  end

  assign res_o = res;

  // Hold transfer state, advance on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q    <= 1'b0;
      phase_q   <= PH_START;
      turn_q    <= '0;
      request_q <= '0;
      parity_q  <= 1'b0;
      ack_q     <= '0;
    end else if (item_en_i) begin
      busy_q    <= busy_d;
      phase_q   <= phase_d;
      turn_q    <= turn_d;
      request_q <= request_d;
      parity_q  <= parity_d;
      ack_q     <= ack_d;
    end
  end

  // Data shifter
  always_ff @(posedge clk_i) begin
    if (item_en_i) begin
      word_q <= word_d;
    end
  end

endmodule

// ===== design/swd_write_transfer_serializer.sv =====
// ----------------------------------------------------------------------------
// SWD write transfer serializer
// Serial-wire write transaction engine, one serial clock per tick item.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries items. A start item
//   (action_i = 0) loads request_i and write_word_i and gives no result.
//   Each tick item (action_i = 1) is one serial clock; it samples line_in_i
//   and gives one result item on the output channel (out_valid_o /
//   out_stall_i): line level, drive enable, and on the final data parity
//   tick done_res_o with the sampled ack_code_o.
//   A tick's result shows in the cycle after the item is accepted. One item
//   is accepted every clock unless a held result is stalled: the output
//   register frees up in the same cycle its result is taken.
//   While the receiver stalls a held result, in_stall_o is raised and no
//   item is accepted; the held result does not change.
//   cfg_we_i / cfg_wdata_i set the turnaround length; write while idle.
//   Reset clears the engine to idle (line driven high on ticks), empties the
//   output register and sets the turnaround length to 1.
// ----------------------------------------------------------------------------
module swd_write_transfer_serializer (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [swdw_pkg::TURN_W-1:0]     cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            action_i,
  input  logic [swdw_pkg::REQ_BITS-1:0]   request_i,
  input  logic [swdw_pkg::DATA_BITS-1:0]  write_word_i,
  input  logic                            line_in_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            line_out_o,
  output logic                            line_drive_o,
  output logic [swdw_pkg::ACK_BITS-1:0]   ack_code_o,
  output logic                            done_res_o
);
  import swdw_pkg::*;

  logic [TURN_W-1:0] turnaround_q;
  logic              in_accept;
  logic              out_valid_q, out_valid_d;
  swdw_res_t         res;
  swdw_res_t         res_q;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  // Turnaround length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      turnaround_q <= 3'd1;
    end else if (cfg_we_i) begin
      turnaround_q <= cfg_wdata_i;
    end
  end

  swdw_engine u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_en_i    (in_accept),
    .action_i     (action_i),
    .request_i    (request_i),
    .write_word_i (write_word_i),
    .line_in_i    (line_in_i),
    .turnaround_i (turnaround_q),
    .res_o        (res)
  );

  // Load on tick items, drop once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (in_accept && action_i == ACT_TICK) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (in_accept && action_i == ACT_TICK) begin
      res_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign line_out_o   = res_q.line_out;
  assign line_drive_o = res_q.line_drive;
  assign ack_code_o   = res_q.ack_code;
  assign done_res_o   = res_q.done_res;

endmodule

// ===== design/swdw_checker.sv =====
// ----------------------------------------------------------------------------
// SWD write serializer port checker
// Port-level properties of the serializer, bound to the top level.
// ----------------------------------------------------------------------------
`include "swd_write_transfer_serializer_defines.svh"

module swdw_checker (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_stall_o,
  input  logic                            action_i,
  input  logic                            out_valid_o,
  input  logic                            out_stall_i,
  input  logic                            line_out_o,
  input  logic                            line_drive_o,
  input  logic [swdw_pkg::ACK_BITS-1:0]   ack_code_o,
  input  logic                            done_res_o
);
  import swdw_pkg::*;

  logic in_accept;

  assign in_accept = in_valid_i & ~in_stall_o;

  // Hold a stalled result
  `SWDW_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(line_out_o) && $stable(line_drive_o) &&
    $stable(ack_code_o) && $stable(done_res_o), "stalled result changed")

  // A released line reads low
  `SWDW_ASSERT_NOW(a_released_low, out_valid_o && !line_drive_o, !line_out_o,
    "line high while released")

  // Ack shows only on the done tick
  `SWDW_ASSERT_NOW(a_ack_on_done, out_valid_o && !done_res_o, ack_code_o == '0,
    "ack code outside done tick")

  // The done tick drives the line
  `SWDW_ASSERT_NOW(a_done_driven, out_valid_o && done_res_o, line_drive_o,
    "done tick not driven")

  // A start item leaves no result behind
  `SWDW_ASSERT_NEXT(a_start_silent, in_accept && action_i == ACT_START, !out_valid_o,
    "start item produced a result")

endmodule

bind swd_write_transfer_serializer swdw_checker u_swdw_checker (.*);
